// File: hdl/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg: shared types and constants for the Gauss-Seidel sweep block
// Register indexes, request codes, datapath widths and the control struct
// passed from the sequencer to the arithmetic unit.
// ----------------------------------------------------------------------------
package gss_pkg;

   localparam int DEF_MAX_UNKNOWNS = 16;
   localparam int DEF_FRAC_BITS    = 16;

   localparam int VAL_W  = 32;
   localparam int PROD_W = 64;
   localparam int ACC_W  = 72;
   localparam int REM_W  = VAL_W + 1;
   localparam int DCNT_W = $clog2(ACC_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_IN_USE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_EPSILON = 2'd1;

   localparam logic [1:0] REQ_WRITE_MATRIX = 2'd0;
   localparam logic [1:0] REQ_WRITE_RHS    = 2'd1;
   localparam logic [1:0] REQ_WRITE_X      = 2'd2;
   localparam logic [1:0] REQ_RUN_SWEEP    = 2'd3;

   typedef struct packed {
      logic init;
      logic mac;
      logic div_load;
      logic div_step;
   } gss_ctrl_type;

endpackage

// File: hdl/gauss_seidel_sweep.sv
// ----------------------------------------------------------------------------
// gauss_seidel_sweep: in-place Gauss-Seidel pass over an on-chip system
// Loads matrix, right-hand side and start vector entry by entry, then runs
// one sweep per request, emitting every solution entry of the sweep.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | type, row, col, value
//   rsp     | out       | rsp_valid/rsp_ready   | index, value, flags, last
//   csr     | in        | csr_we                | index, data
//
// Loads are taken while idle. Each sweep row runs n-1 multiply-accumulates
// through the single multiplier, skipping the diagonal, then, when the pivot
// passes, ACC_W bit-serial divider steps. Reset sets the CSRs and clears the
// solution store. A stalled result holds the sequencer before the next row.
// ----------------------------------------------------------------------------
module gauss_seidel_sweep
   import gss_pkg::*;
#(
   parameter int MAX_UNKNOWNS = DEF_MAX_UNKNOWNS,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_type,
   input  logic [3:0]              req_row_index,
   input  logic [3:0]              req_col_index,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_x_index,
   output logic signed [VAL_W-1:0] rsp_x_value,
   output logic                    rsp_was_updated,
   output logic                    rsp_saturated,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_UNKNOWNS);
   localparam int ADDR_W = $clog2(MAX_UNKNOWNS * MAX_UNKNOWNS);

   typedef enum logic [2:0] {
      S_IDLE, S_ROW, S_DIAG, S_MAC, S_DRAIN, S_DIV, S_WB
   } state_type;

   function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
      mat_addr = ADDR_W'(r) * ADDR_W'(MAX_UNKNOWNS) + ADDR_W'(c);
   endfunction

   logic signed [VAL_W-1:0] mat_mem [MAX_UNKNOWNS*MAX_UNKNOWNS];
   logic signed [VAL_W-1:0] rhs_mem [MAX_UNKNOWNS];
   logic signed [VAL_W-1:0] x_mem   [MAX_UNKNOWNS];
   logic [MAX_UNKNOWNS-1:0] x_valid_ff;

   state_type               state_ff, state_in;
   logic [4:0]              size_ff;
   logic [CSR_DATA_W-1:0]   eps_ff;
   logic [IDX_W-1:0]        i_ff, i_in, j_ff, j_in, nm1_ff, nm1_in;
   logic [DCNT_W-1:0]       cnt_ff, cnt_in;
   logic                    upd_ff, upd_in;
   logic                    rd_v_ff, rd_v_in;
   logic signed [VAL_W-1:0] mat_rd_ff, rhs_rd_ff, x_mem_rd_ff;
   logic                    x_vrd_ff;
   logic signed [VAL_W-1:0] diag_ff, diag_in, xold_ff, xold_in;
   logic                    rsp_valid_ff;
   logic [3:0]              rsp_idx_ff;
   logic signed [VAL_W-1:0] rsp_val_ff;
   logic                    rsp_upd_ff, rsp_sat_ff, rsp_last_ff;

   logic [ADDR_W-1:0]       mat_raddr;
   logic [IDX_W-1:0]        x_raddr;
   logic signed [VAL_W-1:0] x_rd;
   logic [VAL_W-1:0]        dmag;
   logic                    guard_ok;
   logic                    wb_go;
   logic                    load_go;
   logic                    x_we;
   logic [IDX_W-1:0]        x_waddr;
   logic signed [VAL_W-1:0] x_wdata;
   gss_ctrl_type            ctrl;
   logic                    mac_busy;
   logic signed [VAL_W-1:0] q_value;
   logic                    q_sat;

   gss_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .b_value    (rhs_rd_ff),
      .a_value    (mat_rd_ff),
      .x_value    (x_rd),
      .diag_value (diag_ff),
      .d_mag      (dmag),
      .mac_busy   (mac_busy),
      .q_value    (q_value),
      .q_sat      (q_sat)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign load_go   = req_valid && req_ready && (req_type != REQ_RUN_SWEEP)
                      && (int'(req_row_index) < MAX_UNKNOWNS);
   assign x_rd      = x_vrd_ff ? x_mem_rd_ff : '0;
   assign dmag      = diag_ff[VAL_W-1] ? VAL_W'(-diag_ff) : VAL_W'(diag_ff);
   assign guard_ok  = dmag > {1'b0, eps_ff};
   assign wb_go     = (state_ff == S_WB) && (!rsp_valid_ff || rsp_ready);
   assign mat_raddr = (state_ff == S_ROW) ? mat_addr(i_ff, i_ff) : mat_addr(i_ff, j_ff);
   assign x_raddr   = (state_ff == S_ROW) ? i_ff : j_ff;

   always_comb begin
      if (size_ff == 5'd0) begin
         nm1_in = '0;
      end else if (int'(size_ff) > MAX_UNKNOWNS) begin
         nm1_in = IDX_W'(MAX_UNKNOWNS - 1);
      end else begin
         nm1_in = IDX_W'(size_ff - 5'd1);
      end
   end

   always_comb begin
      x_we    = 1'b0;
      x_waddr = IDX_W'(req_row_index);
      x_wdata = req_value;
      if (load_go && req_type == REQ_WRITE_X) begin
         x_we = 1'b1;
      end else if (wb_go && upd_ff) begin
         x_we    = 1'b1;
         x_waddr = i_ff;
         x_wdata = q_value;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cnt_in   = cnt_ff;
      upd_in   = upd_ff;
      rd_v_in  = 1'b0;
      diag_in  = diag_ff;
      xold_in  = xold_ff;
      ctrl     = '0;
      ctrl.mac = rd_v_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_type == REQ_RUN_SWEEP) begin
               i_in     = '0;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            state_in = S_DIAG;
         end
         S_DIAG: begin
            diag_in   = mat_rd_ff;
            xold_in   = x_rd;
            ctrl.init = 1'b1;
            j_in      = '0;
            state_in  = S_MAC;
         end
         S_MAC: begin
            rd_v_in = (j_ff != i_ff);
            if (j_ff == nm1_ff) begin
               state_in = S_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!rd_v_ff && !mac_busy) begin
               upd_in = guard_ok;
               if (guard_ok) begin
                  ctrl.div_load = 1'b1;
                  cnt_in        = DCNT_W'(ACC_W - 1);
                  state_in      = S_DIV;
               end else begin
                  state_in = S_WB;
               end
            end
         end
         S_DIV: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (wb_go) begin
               if (i_ff == nm1_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_ROW;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= 5'd16;
         eps_ff       <= CSR_DATA_W'(1);
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         nm1_ff       <= '0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= rd_v_in;
         if (csr_we && csr_index == CSR_SIZE_IN_USE) begin
            size_ff <= csr_wdata[4:0];
         end
         if (csr_we && csr_index == CSR_PIVOT_EPSILON) begin
            eps_ff <= csr_wdata;
         end
         if (state_ff == S_IDLE && req_valid && req_type == REQ_RUN_SWEEP) begin
            nm1_ff <= nm1_in;
         end
         if (wb_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      cnt_ff  <= cnt_in;
      upd_ff  <= upd_in;
      diag_ff <= diag_in;
      xold_ff <= xold_in;
      if (wb_go) begin
         rsp_idx_ff  <= 4'(i_ff);
         rsp_val_ff  <= upd_ff ? q_value : xold_ff;
         rsp_upd_ff  <= upd_ff;
         rsp_sat_ff  <= upd_ff & q_sat;
         rsp_last_ff <= (i_ff == nm1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (load_go && req_type == REQ_WRITE_MATRIX
          && int'(req_col_index) < MAX_UNKNOWNS) begin
         mat_mem[mat_addr(IDX_W'(req_row_index), IDX_W'(req_col_index))] <= req_value;
      end
      mat_rd_ff <= mat_mem[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (load_go && req_type == REQ_WRITE_RHS) begin
         rhs_mem[IDX_W'(req_row_index)] <= req_value;
      end
      rhs_rd_ff <= rhs_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[x_waddr] <= x_wdata;
      end
      x_mem_rd_ff <= x_mem[x_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= '0;
         x_vrd_ff   <= 1'b0;
      end else begin
         if (x_we) begin
            x_valid_ff[x_waddr] <= 1'b1;
         end
         x_vrd_ff <= x_valid_ff[x_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_index     = rsp_idx_ff;
   assign rsp_x_value     = rsp_val_ff;
   assign rsp_was_updated = rsp_upd_ff;
   assign rsp_saturated   = rsp_sat_ff;
   assign rsp_last        = rsp_last_ff;

   a_sat_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_saturated || rsp_was_updated))
      else $error("saturated flag on an entry that was not updated");

   a_div_only_on_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> upd_ff)
      else $error("divider running for a row that failed the pivot guard");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rd_v_ff && !mac_busy))
      else $error("multiply pipeline busy while accepting a transfer");

endmodule

// File: hdl/gss_arith.sv
// ----------------------------------------------------------------------------
// gss_arith: shared multiply-accumulate and restoring divider
// One registered 32x32 multiplier feeding a wide accumulator, and a divider
// that retires one quotient bit per cycle, with saturation to 32 bits.
// ----------------------------------------------------------------------------
module gss_arith
   import gss_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gss_ctrl_type            ctrl,
   input  logic signed [VAL_W-1:0] b_value,
   input  logic signed [VAL_W-1:0] a_value,
   input  logic signed [VAL_W-1:0] x_value,
   input  logic signed [VAL_W-1:0] diag_value,
   input  logic        [VAL_W-1:0] d_mag,
   output logic                    mac_busy,
   output logic signed [VAL_W-1:0] q_value,
   output logic                    q_sat
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_v_ff, prod_v_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic        [ACC_W-1:0]  m_ff, m_in;
   logic        [REM_W-1:0]  r_ff, r_in;
   logic        [REM_W-1:0]  q_ff, q_in;
   logic                     sticky_ff, sticky_in;
   logic                     neg_ff, neg_in;
   logic        [VAL_W-1:0]  d_ff, d_in;
   logic        [REM_W-1:0]  r_sh;
   logic                     ge;
   logic        [REM_W-1:0]  limit;
   logic        [VAL_W-1:0]  mag;

   always_comb begin
      prod_in   = a_value * x_value;
      prod_v_in = ctrl.mac;
      acc_in    = acc_ff;
      if (ctrl.init) begin
         acc_in = ACC_W'(b_value) <<< FRAC_BITS;
      end else if (prod_v_ff) begin
         acc_in = acc_ff - ACC_W'(prod_ff);
      end
      r_sh      = {r_ff[REM_W-2:0], m_ff[ACC_W-1]};
      ge        = r_sh >= {1'b0, d_ff};
      m_in      = m_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      sticky_in = sticky_ff;
      neg_in    = neg_ff;
      d_in      = d_ff;
      if (ctrl.div_load) begin
         neg_in    = acc_ff[ACC_W-1] ^ diag_value[VAL_W-1];
         m_in      = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
         r_in      = '0;
         q_in      = '0;
         sticky_in = 1'b0;
         d_in      = d_mag;
      end else if (ctrl.div_step) begin
         m_in      = m_ff << 1;
         r_in      = ge ? r_sh - {1'b0, d_ff} : r_sh;
         q_in      = {q_ff[REM_W-2:0], ge};
         sticky_in = sticky_ff | q_ff[REM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= prod_v_in;
      end
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      m_ff      <= m_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      sticky_ff <= sticky_in;
      neg_ff    <= neg_in;
      d_ff      <= d_in;
   end

   always_comb begin
      limit    = neg_ff ? REM_W'(33'h0_8000_0000) : REM_W'(33'h0_7FFF_FFFF);
      q_sat    = sticky_ff | (q_ff > limit);
      mag      = q_sat ? limit[VAL_W-1:0] : q_ff[VAL_W-1:0];
      q_value  = neg_ff ? VAL_W'(-mag) : VAL_W'(mag);
      mac_busy = prod_v_ff;
   end

endmodule
